/* rtl/clipped_framebuffer_writer_macros.svh */
// Assertion macros for the clipped frame buffer writer checker.
// No dependencies; included by the files that assert.
`ifndef CLIPPED_FRAMEBUFFER_WRITER_MACROS_SVH
`define CLIPPED_FRAMEBUFFER_WRITER_MACROS_SVH

// same-cycle implication
`define CFW_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define CFW_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/cfw_pkg.sv */
// Shared types, codes and colour conversions for the clipped frame buffer writer.
// No dependencies.
package cfw_pkg;

	localparam logic [2:0] OP_SET       = 3'd0;
	localparam logic [2:0] OP_GET       = 3'd1;
	localparam logic [2:0] OP_FILL      = 3'd2;
	localparam logic [2:0] OP_WIN_BEGIN = 3'd3;
	localparam logic [2:0] OP_WIN_PIXEL = 3'd4;

	localparam logic [1:0] CF_MONO   = 2'd0;
	localparam logic [1:0] CF_GRAY8  = 2'd1;
	localparam logic [1:0] CF_RGB565 = 2'd2;
	localparam logic [1:0] CF_RGB888 = 2'd3;

	localparam logic [31:0] PIX_RESET = 32'h4D4D4D4D;
	localparam logic [7:0]  ALPHA_OPAQUE = 8'hFF;
	localparam logic [9:0]  THIRD_MUL = 10'd683;   // 683/2048 ~ 1/3, exact for sums to 765

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_RUN,
		ST_FILL
	} fsm_t;

	typedef struct packed {
		logic [31:0] read_color;
		logic        outside;
	} rsp_t;

	function automatic logic [23:0] dev_to_rgb(input logic [1:0] fmt, input logic [31:0] c);
		logic [23:0] r;
		case (fmt)
			CF_MONO:   r = (c < 32'd128) ? 24'h000000 : 24'hFFFFFF;
			CF_GRAY8:  r = {c[7:0], c[7:0], c[7:0]};
			CF_RGB565: r = {c[15:11], 3'b000, c[10:5], 2'b00, c[4:0], 3'b000};
			default:   r = c[23:0];
		endcase
		return r;
	endfunction

	function automatic logic [7:0] rgb_to_gray(input logic [31:0] c);
		logic [9:0]  sum;
		logic [19:0] prod;
		sum  = 10'(c[23:16]) + 10'(c[15:8]) + 10'(c[7:0]);
		prod = 20'(sum) * 20'(THIRD_MUL);
		return prod[18:11];
	endfunction

	function automatic logic [31:0] rgb_to_dev(input logic [1:0] fmt, input logic [31:0] c);
		logic [7:0]  g;
		logic [31:0] r;
		g = rgb_to_gray(c);
		case (fmt)
			CF_MONO:   r = {31'd0, g[7]};
			CF_GRAY8:  r = {24'd0, g};
			CF_RGB565: r = {16'd0, c[23:19], c[15:10], c[7:3]};
			default:   r = c;
		endcase
		return r;
	endfunction

endpackage

/* rtl/cfw_intf.sv */
// Command and response channel interfaces (valid/ready) for the frame buffer writer.
// No dependencies.
interface cfw_cmd_if;
	logic               valid;
	logic               ready;
	logic [2:0]         op;
	logic signed [15:0] x_start;
	logic signed [15:0] y_start;
	logic signed [15:0] x_end;
	logic signed [15:0] y_end;
	logic [31:0]        color;

	modport source (output valid, op, x_start, y_start, x_end, y_end, color, input ready);
	modport sink   (input valid, op, x_start, y_start, x_end, y_end, color, output ready);
endinterface

interface cfw_rsp_if;
	logic        valid;
	logic        ready;
	logic [31:0] read_color;
	logic        outside;

	modport source (output valid, read_color, outside, input ready);
	modport sink   (input valid, read_color, outside, output ready);
endinterface

/* rtl/clipped_framebuffer_writer.sv */
// Clipped frame buffer writer: ARGB screen store with point, fill and window access.
// Uses cfw_pkg, cfw_cmd_if, cfw_rsp_if. Point set/get and window pixels: one item per cycle while cmd.ready is high;
// a get point result passes the store access stage and the read data register before it is
// queued and offered. cmd.ready drops while 4 results are queued or in flight, and during
// a fill, which writes its clipped area at one store write per cycle. After reset the store
// is swept to 0x4D4D4D4D with cmd.ready low; cfg writes always taken.
module clipped_framebuffer_writer #(
	parameter int SCREEN_WIDTH  = 320,
	parameter int SCREEN_HEIGHT = 240
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cfg_we,
	input  logic [1:0]     cfg_data,
	cfw_cmd_if.sink        cmd,
	cfw_rsp_if.source      rsp
);
	import cfw_pkg::*;

	localparam int DEPTH = SCREEN_WIDTH * SCREEN_HEIGHT;
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int XW = (SCREEN_WIDTH > 1) ? $clog2(SCREEN_WIDTH) : 1;
	localparam int YW = (SCREEN_HEIGHT > 1) ? $clog2(SCREEN_HEIGHT) : 1;
	localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);
	localparam logic [AW-1:0] ROW_PITCH = AW'(SCREEN_WIDTH);
	localparam logic signed [15:0] X_MAX = 16'(SCREEN_WIDTH - 1);
	localparam logic signed [15:0] Y_MAX = 16'(SCREEN_HEIGHT - 1);
	localparam int RSP_DEPTH = 4;
	localparam int PW = $clog2(RSP_DEPTH);
	localparam int CW = $clog2(RSP_DEPTH + 1);

	function automatic logic [AW-1:0] pix_addr(input logic [YW-1:0] y, input logic [XW-1:0] x);
		return AW'(y) * ROW_PITCH + AW'(x);
	endfunction

	logic [31:0]        screen_q [DEPTH];
	logic [1:0]         fmt_q;
	fsm_t               state_q, state_d;
	logic [AW-1:0]      clr_addr_q;

	logic [XW-1:0]      fx_q, fx0_q, fx1_q;
	logic [YW-1:0]      fy_q, fy1_q;
	logic [31:0]        fill_data_q;

	logic signed [15:0] win_left_q, win_right_q, win_bottom_q, cur_col_q, cur_row_q;
	logic               win_active_q;

	logic               wr_en_s1, rd_en_s1, outside_s1;
	logic [AW-1:0]      addr_s1;
	logic [31:0]        wdata_s1;
	logic               wr_en_d, rd_en_d, outside_d;
	logic [AW-1:0]      addr_d;
	logic [31:0]        wdata_d;

	logic               get_s2, outside_s2;
	logic [31:0]        rd_data_s2;

	rsp_t               fifo_q [RSP_DEPTH];
	logic [PW-1:0]      wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]      cnt_q;
	logic [CW:0]        in_flight;
	rsp_t               push_data;
	logic               push, pop;

	logic               cmd_acc, pt_on, fill_go, fill_row_end, fill_last;
	logic signed [15:0] pt_x, pt_y, cx0, cy0, cx1, cy1;
	logic [31:0]        pt_rgb;

	// front end
	assign in_flight = (CW+1)'(cnt_q) + (CW+1)'(rd_en_s1) + (CW+1)'(get_s2);
	assign cmd.ready = (state_q == ST_RUN) && (in_flight < (CW+1)'(RSP_DEPTH));
	assign cmd_acc   = cmd.valid && cmd.ready;

	assign pt_x   = (cmd.op == OP_WIN_PIXEL) ? cur_col_q : cmd.x_start;
	assign pt_y   = (cmd.op == OP_WIN_PIXEL) ? cur_row_q : cmd.y_start;
	assign pt_on  = (pt_x >= 0) && (pt_y >= 0) && (pt_x <= X_MAX) && (pt_y <= Y_MAX);
	assign pt_rgb = {ALPHA_OPAQUE, dev_to_rgb(fmt_q, cmd.color)};

	assign cx0 = (cmd.x_start < 0) ? 16'sd0 : cmd.x_start;
	assign cy0 = (cmd.y_start < 0) ? 16'sd0 : cmd.y_start;
	assign cx1 = (cmd.x_end > X_MAX) ? X_MAX : cmd.x_end;
	assign cy1 = (cmd.y_end > Y_MAX) ? Y_MAX : cmd.y_end;
	assign fill_go = cmd_acc && (cmd.op == OP_FILL) && (cx0 <= cx1) && (cy0 <= cy1);

	assign fill_row_end = (fx_q == fx1_q);
	assign fill_last    = fill_row_end && (fy_q == fy1_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fmt_q <= CF_RGB565;
		end else if (cfg_we) begin
			fmt_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		wr_en_d    = 1'b0;
		rd_en_d    = 1'b0;
		outside_d  = 1'b0;
		addr_d     = pix_addr(pt_y[YW-1:0], pt_x[XW-1:0]);
		wdata_d    = pt_rgb;
		case (state_q)
			ST_CLEAR: begin
				wr_en_d = 1'b1;
				addr_d  = clr_addr_q;
				wdata_d = PIX_RESET;
				if (clr_addr_q == LAST_ADDR) begin
					state_d = ST_RUN;
				end
			end
			ST_FILL: begin
				wr_en_d = 1'b1;
				addr_d  = pix_addr(fy_q, fx_q);
				wdata_d = fill_data_q;
				if (fill_last) begin
					state_d = ST_RUN;
				end
			end
			ST_RUN: begin
				if (cmd_acc) begin
					case (cmd.op)
						OP_SET:       wr_en_d = pt_on;
						OP_WIN_PIXEL: wr_en_d = pt_on && win_active_q;
						OP_GET: begin
							rd_en_d   = 1'b1;
							outside_d = !pt_on;
						end
						default: ;
					endcase
				end
				if (fill_go) begin
					state_d = ST_FILL;
				end
			end
			default: state_d = ST_RUN;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q <= '0;
		end else if (state_q == ST_CLEAR) begin
			clr_addr_q <= clr_addr_q + AW'(1);
		end
	end

	// fill sequencer
	always_ff @(posedge clk) begin
		if (fill_go) begin
			fx0_q       <= cx0[XW-1:0];
			fx1_q       <= cx1[XW-1:0];
			fy1_q       <= cy1[YW-1:0];
			fx_q        <= cx0[XW-1:0];
			fy_q        <= cy0[YW-1:0];
			fill_data_q <= pt_rgb;
		end else if (state_q == ST_FILL) begin
			if (fill_row_end) begin
				fx_q <= fx0_q;
				fy_q <= fy_q + YW'(1);
			end else begin
				fx_q <= fx_q + XW'(1);
			end
		end
	end

	// window cursor
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_left_q   <= '0;
			win_right_q  <= '0;
			win_bottom_q <= '0;
			cur_col_q    <= '0;
			cur_row_q    <= '0;
			win_active_q <= 1'b0;
		end else if (cmd_acc && (cmd.op == OP_WIN_BEGIN)) begin
			win_left_q   <= cmd.x_start;
			win_right_q  <= cmd.x_end;
			win_bottom_q <= cmd.y_end;
			cur_col_q    <= cmd.x_start;
			cur_row_q    <= cmd.y_start;
			win_active_q <= (cmd.x_start <= cmd.x_end) && (cmd.y_start <= cmd.y_end);
		end else if (cmd_acc && (cmd.op == OP_WIN_PIXEL) && win_active_q) begin
			if (cur_col_q >= win_right_q) begin
				cur_col_q <= win_left_q;
				if (cur_row_q >= win_bottom_q) begin
					win_active_q <= 1'b0;
				end else begin
					cur_row_q <= cur_row_q + 16'sd1;
				end
			end else begin
				cur_col_q <= cur_col_q + 16'sd1;
			end
		end
	end

	// store access stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_en_s1 <= 1'b0;
			rd_en_s1 <= 1'b0;
			get_s2   <= 1'b0;
		end else begin
			wr_en_s1 <= wr_en_d;
			rd_en_s1 <= rd_en_d;
			get_s2   <= rd_en_s1;
		end
	end

	always_ff @(posedge clk) begin
		addr_s1    <= addr_d;
		wdata_s1   <= wdata_d;
		outside_s1 <= outside_d;
		outside_s2 <= outside_s1;
	end

	always_ff @(posedge clk) begin
		if (wr_en_s1) begin
			screen_q[addr_s1] <= wdata_s1;
		end
		if (rd_en_s1) begin
			rd_data_s2 <= screen_q[addr_s1];
		end
	end

	// result queue
	assign push = get_s2;
	assign pop  = rsp.valid && rsp.ready;
	assign push_data.read_color = outside_s2 ? 32'd0 : rgb_to_dev(fmt_q, rd_data_s2);
	assign push_data.outside    = outside_s2;

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PW'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

	assign rsp.valid      = (cnt_q != '0);
	assign rsp.read_color = fifo_q[rd_ptr_q].read_color;
	assign rsp.outside    = fifo_q[rd_ptr_q].outside;

endmodule

/* rtl/cfw_checker.sv */
// Port-level checks for the clipped frame buffer writer, bound to the top level.
// Uses cfw_pkg and clipped_framebuffer_writer_macros.svh.
`include "clipped_framebuffer_writer_macros.svh"

module cfw_checker #(
	parameter int SCREEN_WIDTH  = 320,
	parameter int SCREEN_HEIGHT = 240
) (
	input logic               clk,
	input logic               arst_n,
	input logic               cmd_valid,
	input logic               cmd_ready,
	input logic [2:0]         cmd_op,
	input logic signed [15:0] cmd_x_start,
	input logic signed [15:0] cmd_y_start,
	input logic signed [15:0] cmd_x_end,
	input logic signed [15:0] cmd_y_end,
	input logic               rsp_valid,
	input logic               rsp_ready,
	input logic [31:0]        rsp_read_color,
	input logic               rsp_outside
);
	import cfw_pkg::*;

	localparam logic signed [15:0] X_MAX = 16'(SCREEN_WIDTH - 1);
	localparam logic signed [15:0] Y_MAX = 16'(SCREEN_HEIGHT - 1);

	logic cmd_acc, fill_busy;

	assign cmd_acc   = cmd_valid && cmd_ready;
	assign fill_busy = cmd_acc && (cmd_op == OP_FILL) && (cmd_x_start >= 0) &&
		(cmd_y_start >= 0) && (cmd_x_start <= X_MAX) && (cmd_y_start <= Y_MAX) &&
		(cmd_x_start <= cmd_x_end) && (cmd_y_start <= cmd_y_end);

	`CFW_ASSERT_NXT(a_rsp_hold, clk, arst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_read_color) && $stable(rsp_outside), "stalled item changed or dropped")
	`CFW_ASSERT_IMP(a_rsp_origin, clk, arst_n, $rose(rsp_valid), $past(cmd_acc && (cmd_op == OP_GET), 3), "result without get point three cycles before")
	`CFW_ASSERT_NXT(a_fill_stall, clk, arst_n, fill_busy, !cmd_ready, "fill on screen did not hold off commands")
	`CFW_ASSERT_IMP(a_outside_zero, clk, arst_n, rsp_valid && rsp_outside, rsp_read_color == 32'd0, "off-screen read with non-zero colour")

endmodule

bind clipped_framebuffer_writer cfw_checker #(
	.SCREEN_WIDTH  (SCREEN_WIDTH),
	.SCREEN_HEIGHT (SCREEN_HEIGHT)
) u_cfw_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.cmd_valid      (cmd.valid),
	.cmd_ready      (cmd.ready),
	.cmd_op         (cmd.op),
	.cmd_x_start    (cmd.x_start),
	.cmd_y_start    (cmd.y_start),
	.cmd_x_end      (cmd.x_end),
	.cmd_y_end      (cmd.y_end),
	.rsp_valid      (rsp.valid),
	.rsp_ready      (rsp.ready),
	.rsp_read_color (rsp.read_color),
	.rsp_outside    (rsp.outside)
);

/* tb/tb_clipped_framebuffer_writer.sv */
// Self-checking testbench for clipped_framebuffer_writer: point, fill and window traffic
// against a behavioural screen store, with item-level checks of every get point result.
// Depends on cfw_pkg, cfw_cmd_if, cfw_rsp_if and the clipped_framebuffer_writer RTL.
`timescale 1ns / 100ps

module tb_clipped_framebuffer_writer;
	import cfw_pkg::*;

	localparam int SCR_W = 320;
	localparam int SCR_H = 240;
	localparam logic [2:0] OP_RESERVED_LO = 3'd5;
	localparam logic [2:0] OP_RESERVED_HI = 3'd7;
	localparam int SETTLE_CYCLES = 8;

	typedef struct {
		logic [2:0]         op;
		logic signed [15:0] x_start;
		logic signed [15:0] y_start;
		logic signed [15:0] x_end;
		logic signed [15:0] y_end;
		logic [31:0]        color;
	} draw_cmd_t;

	bit         clk;
	logic       arst_n;
	logic       cfg_we;
	logic [1:0] cfg_data;

	cfw_cmd_if cmd_ch();
	cfw_rsp_if rsp_ch();

	clipped_framebuffer_writer #(
		.SCREEN_WIDTH (SCR_W),
		.SCREEN_HEIGHT(SCR_H)
	) dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg_we  (cfg_we),
		.cfg_data(cfg_data),
		.cmd     (cmd_ch),
		.rsp     (rsp_ch)
	);

	// behavioural screen
	logic [31:0] screen_model [SCR_W*SCR_H];
	logic [1:0]  pred_format;
	int          win_left, win_right, win_bottom, cur_col, cur_row;
	bit          win_active;
	rsp_t        expected_reads[$];

	int failures;
	int send_gap_pct;
	int stall_pct;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(negedge clk) begin
		rsp_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
	end

	function automatic logic [31:0] device_to_argb(input logic [1:0] fmt, input logic [31:0] c);
		logic [23:0] rgb;
		case (fmt)
			CF_MONO:   rgb = (c < 32'd128) ? 24'h000000 : 24'hFFFFFF;
			CF_GRAY8:  rgb = 24'(c[7:0]) * 24'h010101;
			CF_RGB565: rgb = (24'(c[15:11]) << 19) | (24'(c[10:5]) << 10) | (24'(c[4:0]) << 3);
			default:   rgb = c[23:0];
		endcase
		return {8'hFF, rgb};
	endfunction

	function automatic logic [31:0] argb_to_device(input logic [1:0] fmt, input logic [31:0] p);
		int unsigned lum;
		lum = (32'(p[23:16]) + 32'(p[15:8]) + 32'(p[7:0])) / 3;
		case (fmt)
			CF_MONO:   return (lum >= 128) ? 32'd1 : 32'd0;
			CF_GRAY8:  return lum;
			CF_RGB565: return {16'd0, p[23:19], p[15:10], p[7:3]};
			default:   return p;
		endcase
	endfunction

	function automatic bit on_screen(input int x, input int y);
		return x >= 0 && y >= 0 && x < SCR_W && y < SCR_H;
	endfunction

	function automatic void store_pixel(input int x, input int y, input logic [31:0] dev);
		if (on_screen(x, y))
			screen_model[y*SCR_W + x] = device_to_argb(pred_format, dev);
	endfunction

	function automatic void apply_draw_cmd(input draw_cmd_t c);
		int xs, ys, xe, ye, x, y;
		rsp_t r;
		xs = c.x_start;
		ys = c.y_start;
		xe = c.x_end;
		ye = c.y_end;
		case (c.op)
			OP_SET: store_pixel(xs, ys, c.color);
			OP_GET: begin
				if (on_screen(xs, ys)) begin
					r.read_color = argb_to_device(pred_format, screen_model[ys*SCR_W + xs]);
					r.outside = 1'b0;
				end else begin
					r.read_color = '0;
					r.outside = 1'b1;
				end
				expected_reads.push_back(r);
			end
			OP_FILL: begin
				for (y = (ys < 0 ? 0 : ys); y <= (ye > SCR_H - 1 ? SCR_H - 1 : ye); y++)
					for (x = (xs < 0 ? 0 : xs); x <= (xe > SCR_W - 1 ? SCR_W - 1 : xe); x++)
						store_pixel(x, y, c.color);
			end
			OP_WIN_BEGIN: begin
				win_left = xs;
				win_right = xe;
				win_bottom = ye;
				cur_col = xs;
				cur_row = ys;
				win_active = (xs <= xe) && (ys <= ye);
			end
			OP_WIN_PIXEL: begin
				if (win_active) begin
					store_pixel(cur_col, cur_row, c.color);
					if (cur_col >= win_right) begin
						cur_col = win_left;
						if (cur_row >= win_bottom)
							win_active = 1'b0;
						else
							cur_row++;
					end else begin
						cur_col++;
					end
				end
			end
			default: ;
		endcase
	endfunction

	task automatic note_failure(input string what);
		failures++;
		if (failures <= 10)
			$display("MISMATCH at %0t: %s", $realtime, what);
	endtask

	always @(posedge clk) begin : track_channels
		draw_cmd_t c;
		rsp_t want;
		if (arst_n) begin
			if (cmd_ch.valid && cmd_ch.ready) begin
				c.op = cmd_ch.op;
				c.x_start = cmd_ch.x_start;
				c.y_start = cmd_ch.y_start;
				c.x_end = cmd_ch.x_end;
				c.y_end = cmd_ch.y_end;
				c.color = cmd_ch.color;
				apply_draw_cmd(c);
			end
			if (rsp_ch.valid && rsp_ch.ready) begin
				if (expected_reads.size() == 0) begin
					note_failure($sformatf("unexpected item read_color=%h outside=%b",
						rsp_ch.read_color, rsp_ch.outside));
				end else begin
					want = expected_reads.pop_front();
					if (want.read_color !== rsp_ch.read_color || want.outside !== rsp_ch.outside)
						note_failure($sformatf("read_color exp %h got %h, outside exp %b got %b",
							want.read_color, rsp_ch.read_color, want.outside, rsp_ch.outside));
				end
			end
			if (cfg_we)
				pred_format = cfg_data;
		end
	end

	task automatic send_draw_cmd(input logic [2:0] op, input logic signed [15:0] xs,
			input logic signed [15:0] ys, input logic signed [15:0] xe,
			input logic signed [15:0] ye, input logic [31:0] color);
		@(negedge clk);
		while ($urandom_range(0, 99) < send_gap_pct) begin
			cmd_ch.valid <= 1'b0;
			@(negedge clk);
		end
		cmd_ch.valid <= 1'b1;
		cmd_ch.op <= op;
		cmd_ch.x_start <= xs;
		cmd_ch.y_start <= ys;
		cmd_ch.x_end <= xe;
		cmd_ch.y_end <= ye;
		cmd_ch.color <= color;
		@(posedge clk);
		while (!cmd_ch.ready)
			@(posedge clk);
	endtask

	task automatic hold_off();
		@(negedge clk);
		cmd_ch.valid <= 1'b0;
	endtask

	task automatic wait_results_drained();
		hold_off();
		while (expected_reads.size() != 0)
			@(posedge clk);
	endtask

	// fills keep the block busy with no result pending
	task automatic settle_pipeline();
		wait_results_drained();
		@(posedge clk);
		while (!cmd_ch.ready)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_color_format(input logic [1:0] fmt);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_data <= fmt;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic logic signed [15:0] rand_coord(input int extent);
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 45)
			return 16'(int'($urandom_range(0, 16)) - 5);
		if (pick < 90)
			return 16'(extent - 12 + int'($urandom_range(0, 16)));
		return 16'($urandom);
	endfunction

	function automatic logic [31:0] rand_color();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 15)
			return $urandom_range(120, 135);
		if (pick < 35)
			return $urandom_range(0, 255);
		if (pick < 60)
			return $urandom_range(0, 65535);
		return $urandom;
	endfunction

	task automatic send_random_get();
		send_draw_cmd(OP_GET, rand_coord(SCR_W), rand_coord(SCR_H), 16'($urandom),
			16'($urandom), $urandom);
	endtask

	task automatic send_random_sequence(ref int sent);
		int pick, w, h, npix, i;
		logic signed [15:0] xs, ys;
		pick = $urandom_range(0, 99);
		xs = rand_coord(SCR_W);
		ys = rand_coord(SCR_H);
		if (pick < 30) begin
			w = $urandom_range(1, 6);
			h = $urandom_range(1, 6);
			send_draw_cmd(OP_WIN_BEGIN, xs, ys, 16'(xs + w - 1), 16'(ys + h - 1), $urandom);
			npix = w * h;
			case ($urandom_range(0, 9))
				0, 1: npix = $urandom_range(0, w * h);
				2, 3: npix += $urandom_range(1, 3);
				default: ;
			endcase
			sent += 1 + npix;
			for (i = 0; i < npix; i++) begin
				if ($urandom_range(0, 9) == 0) begin
					send_random_get();
					sent++;
				end
				send_draw_cmd(OP_WIN_PIXEL, 16'($urandom), 16'($urandom), 16'($urandom),
					16'($urandom), rand_color());
			end
			send_random_get();
			sent++;
		end else if (pick < 55) begin
			send_random_get();
			sent++;
		end else if (pick < 75) begin
			send_draw_cmd(OP_SET, xs, ys, 16'($urandom), 16'($urandom), rand_color());
			sent++;
		end else if (pick < 87) begin
			send_draw_cmd(OP_FILL, xs, ys, 16'(int'(xs) + int'($urandom_range(0, 8)) - 1),
				16'(int'(ys) + int'($urandom_range(0, 8)) - 1), rand_color());
			sent++;
		end else if (pick < 90) begin
			send_draw_cmd(OP_FILL, xs, ys, 16'(int'(xs) + int'($urandom_range(0, 40))),
				16'(int'(ys) + int'($urandom_range(0, 30))), rand_color());
			sent++;
		end else if (pick < 94) begin
			send_draw_cmd(OP_WIN_BEGIN, 16'($urandom), 16'($urandom), 16'($urandom),
				16'($urandom), $urandom);
			npix = $urandom_range(0, 3);
			for (i = 0; i < npix; i++)
				send_draw_cmd(OP_WIN_PIXEL, 16'($urandom), 16'($urandom), 16'($urandom),
					16'($urandom), $urandom);
			sent += 1 + npix;
		end else if (pick < 97) begin
			send_draw_cmd(OP_WIN_PIXEL, 16'($urandom), 16'($urandom), 16'($urandom),
				16'($urandom), $urandom);
			sent++;
		end else begin
			send_draw_cmd(3'($urandom_range(OP_RESERVED_LO, OP_RESERVED_HI)), 16'($urandom),
				16'($urandom), 16'($urandom), 16'($urandom), $urandom);
			sent++;
		end
	endtask

	task automatic test_power_up_state();
		write_color_format(CF_RGB565);
		send_draw_cmd(OP_WIN_PIXEL, 0, 0, 0, 0, 32'hFFFFFFFF);
		send_draw_cmd(OP_GET, 0, 0, 0, 0, 0);
		send_draw_cmd(OP_GET, 319, 239, 0, 0, 0);
		send_draw_cmd(OP_GET, -1, 0, 0, 0, 0);
		send_draw_cmd(OP_GET, 320, 0, 0, 0, 0);
		send_draw_cmd(OP_GET, 0, 240, 0, 0, 0);
		send_draw_cmd(OP_GET, -32768, 32767, 0, 0, 0);
		send_draw_cmd(OP_RESERVED_LO, 0, 0, 319, 239, 32'hFFFFFFFF);
		send_draw_cmd(OP_RESERVED_HI, 0, 0, 319, 239, 32'h0);
	endtask

	task automatic test_point_access();
		send_draw_cmd(OP_SET, 0, 0, 0, 0, 32'hFFFFFFFF);
		send_draw_cmd(OP_GET, 0, 0, 0, 0, 0);
		send_draw_cmd(OP_SET, 319, 239, 0, 0, 32'h0);
		send_draw_cmd(OP_GET, 319, 239, 0, 0, 0);
		send_draw_cmd(OP_SET, -1, 1, 0, 0, 32'h0000F81F);
		send_draw_cmd(OP_SET, 320, 0, 0, 0, 32'h0000F81F);
		send_draw_cmd(OP_SET, 5, -1, 0, 0, 32'h0000F81F);
		send_draw_cmd(OP_SET, 5, 240, 0, 0, 32'h0000F81F);
		send_draw_cmd(OP_GET, 319, 0, 0, 0, 0);
		send_draw_cmd(OP_GET, 0, 1, 0, 0, 0);
		send_draw_cmd(OP_GET, 5, 0, 0, 0, 0);
	endtask

	task automatic test_fill_clipping();
		send_draw_cmd(OP_FILL, -32768, -32768, 32767, 32767, 32'h00001234);
		send_draw_cmd(OP_FILL, -3, -2, 2, 1, 32'h0000F800);
		send_draw_cmd(OP_FILL, 5, 5, 4, 9, 32'h000007E0);
		send_draw_cmd(OP_FILL, 5, 9, 9, 5, 32'h000007E0);
		send_draw_cmd(OP_FILL, 317, 238, 32767, 32767, 32'h0000001F);
		send_draw_cmd(OP_GET, 0, 0, 0, 0, 0);
		send_draw_cmd(OP_GET, 2, 1, 0, 0, 0);
		send_draw_cmd(OP_GET, 3, 1, 0, 0, 0);
		send_draw_cmd(OP_GET, 5, 5, 0, 0, 0);
		send_draw_cmd(OP_GET, 318, 239, 0, 0, 0);
		send_draw_cmd(OP_GET, 316, 239, 0, 0, 0);
	endtask

	task automatic test_window_clipping();
		int i;
		send_draw_cmd(OP_WIN_BEGIN, -2, -1, 2, 1, 0);
		for (i = 0; i < 17; i++)
			send_draw_cmd(OP_WIN_PIXEL, 0, 0, 0, 0, $urandom);
		send_draw_cmd(OP_GET, 0, 0, 0, 0, 0);
		send_draw_cmd(OP_GET, 1, 0, 0, 0, 0);
		send_draw_cmd(OP_GET, 2, 1, 0, 0, 0);
		send_draw_cmd(OP_WIN_BEGIN, 318, 238, 321, 240, 0);
		for (i = 0; i < 12; i++)
			send_draw_cmd(OP_WIN_PIXEL, 0, 0, 0, 0, $urandom);
		send_draw_cmd(OP_GET, 318, 238, 0, 0, 0);
		send_draw_cmd(OP_GET, 319, 239, 0, 0, 0);
		send_draw_cmd(OP_WIN_BEGIN, 10, 10, 9, 20, 0);
		send_draw_cmd(OP_WIN_PIXEL, 0, 0, 0, 0, 32'hFFFFFFFF);
		send_draw_cmd(OP_GET, 10, 10, 0, 0, 0);
	endtask

	task automatic test_color_formats();
		logic [1:0] fmts[4];
		int f, i;
		fmts = '{CF_MONO, CF_GRAY8, CF_RGB565, CF_RGB888};
		for (f = 0; f < 4; f++) begin
			settle_pipeline();
			write_color_format(fmts[f]);
			send_draw_cmd(OP_SET, 16'(40 + 4*f), 40, 0, 0, 32'd127);
			send_draw_cmd(OP_SET, 16'(41 + 4*f), 40, 0, 0, 32'd128);
			send_draw_cmd(OP_SET, 16'(42 + 4*f), 40, 0, 0, 32'hFFFFFFFF);
			send_draw_cmd(OP_SET, 16'(43 + 4*f), 40, 0, 0, $urandom);
			for (i = 0; i < 4; i++)
				send_draw_cmd(OP_GET, 16'(40 + 4*f + i), 40, 0, 0, 0);
			send_draw_cmd(OP_GET, 0, 0, 0, 0, 0);
			send_draw_cmd(OP_GET, 40, 40, 0, 0, 0);
		end
	endtask

	task automatic test_random_traffic(input logic [1:0] fmt, input int gap_pct,
			input int stall, input int items);
		int sent;
		settle_pipeline();
		write_color_format(fmt);
		send_gap_pct = gap_pct;
		stall_pct = stall;
		sent = 0;
		while (sent < items) begin
			if ($urandom_range(0, 29) == 0)
				wait_results_drained();
			send_random_sequence(sent);
		end
	endtask

	initial begin : timeout_guard
		#50_000_000;
		$display("clipped_framebuffer_writer verification failed");
		$finish;
	end

	initial begin : run_tests
		int i, waited;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_data = CF_RGB565;
		cmd_ch.valid = 1'b0;
		cmd_ch.op = OP_SET;
		cmd_ch.x_start = '0;
		cmd_ch.y_start = '0;
		cmd_ch.x_end = '0;
		cmd_ch.y_end = '0;
		cmd_ch.color = '0;
		rsp_ch.ready = 1'b0;
		failures = 0;
		send_gap_pct = 0;
		stall_pct = 0;
		for (i = 0; i < SCR_W*SCR_H; i++)
			screen_model[i] = PIX_RESET;
		pred_format = CF_RGB565;
		win_left = 0;
		win_right = 0;
		win_bottom = 0;
		cur_col = 0;
		cur_row = 0;
		win_active = 1'b0;
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;

		test_power_up_state();
		test_point_access();
		test_fill_clipping();
		test_window_clipping();
		test_color_formats();
		test_random_traffic(CF_RGB888, 0, 0, 80);
		test_random_traffic(CF_MONO, 80, 0, 80);
		test_random_traffic(CF_GRAY8, 0, 80, 80);
		test_random_traffic(CF_RGB565, 30, 30, 80);
		test_random_traffic(CF_RGB888, 0, 0, 80);

		hold_off();
		waited = 0;
		while (expected_reads.size() != 0 && waited < 100_000) begin
			@(posedge clk);
			waited++;
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (failures == 0 && expected_reads.size() == 0)
			$display("clipped_framebuffer_writer verification clean");
		else
			$display("clipped_framebuffer_writer verification failed");
		$finish;
	end

endmodule

/* clipped_framebuffer_writer.f */
+incdir+rtl
rtl/cfw_pkg.sv
rtl/cfw_intf.sv
rtl/clipped_framebuffer_writer.sv
rtl/cfw_checker.sv
tb/tb_clipped_framebuffer_writer.sv
